@@ design/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared sizes, request and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Number of 64-bit words in the busy bitmap.
    localparam int BITMAP_WORDS = 16;
    localparam int WORD_BITS    = 64;

    // Derived widths: word index, word count and capacity in blocks.
    localparam int WORD_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int WCNT_W = $clog2(BITMAP_WORDS + 1);
    localparam int CAP_W  = WCNT_W + 6;

    // Field widths of the ports.
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 3;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd3;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_ALLOC = 3'd4,
        ST_NONE      = 3'd5
    } status_code_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         load;
        logic         scan_next;
        logic         commit_alloc;
        logic         commit_free;
        logic         emit;
        status_code_t code;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              alloc_full;
        logic              pool_empty;
        logic              range_err;
        logic              bit_clear;
        logic              hit;
        logic              last;
    } dp_status_t;

endpackage

@@ design/bba_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Holds the busy bitmap, counters, cursor and limit, scans one bitmap word per
// cycle and registers the result of each request.
// ----------------------------------------------------------------------------
module bba_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bba_pkg::dp_cmd_t              cmd,
    output bba_pkg::dp_status_t           stat,
    input  logic [bba_pkg::MODE_W-1:0]    mode,
    input  logic [bba_pkg::INDEX_W-1:0]   block_index,
    input  logic                          cfg_wr_en,
    input  logic [bba_pkg::COUNT_W-1:0]   cfg_wr_data,
    output logic                          done,
    output logic [bba_pkg::STAT_W-1:0]    status,
    output logic [bba_pkg::INDEX_W-1:0]   result_index,
    output logic [bba_pkg::COUNT_W-1:0]   used_count
);

    // Architectural state.
    logic [bba_pkg::WORD_BITS-1:0] bitmap_reg [bba_pkg::BITMAP_WORDS];
    logic [bba_pkg::COUNT_W-1:0]   used_reg;
    logic [bba_pkg::INDEX_W-1:0]   cursor_reg;
    logic [bba_pkg::COUNT_W-1:0]   limit_reg;

    // Request and scan registers.
    logic [bba_pkg::MODE_W-1:0]    mode_reg;
    logic [bba_pkg::INDEX_W-1:0]   bidx_reg;
    logic [bba_pkg::WORD_W-1:0]    ptr_reg;
    logic [bba_pkg::WCNT_W-1:0]    step_reg;
    logic                          first_reg;

    // Result registers.
    logic                          done_reg;
    logic [bba_pkg::STAT_W-1:0]    status_reg;
    logic [bba_pkg::INDEX_W-1:0]   result_reg;
    logic [bba_pkg::COUNT_W-1:0]   used_out_reg;

    // Combinational signals.
    logic [bba_pkg::COUNT_W:0]     words_sum;
    logic [5:0]                    words_raw;
    logic [bba_pkg::WCNT_W-1:0]    words;
    logic [bba_pkg::CAP_W-1:0]     cap;
    logic [bba_pkg::WORD_W-1:0]    start_word;
    logic [bba_pkg::WORD_W-1:0]    load_ptr;
    logic [bba_pkg::WORD_BITS-1:0] cur_word;
    logic [bba_pkg::WORD_BITS-1:0] first_mask;
    logic [bba_pkg::WORD_BITS-1:0] scan_vec;
    logic [5:0]                    hit_bit;
    logic                          hit;
    logic [bba_pkg::WORD_W+5:0]    blk;
    logic [bba_pkg::WORD_W+6:0]    blk_p1;
    logic [bba_pkg::INDEX_W-1:0]   cursor_next;
    logic [bba_pkg::WORD_W-1:0]    free_word;
    logic                          free_set;
    logic [bba_pkg::INDEX_W-1:0]   from_val;
    logic [bba_pkg::WORD_W-1:0]    ptr_inc;
    logic [bba_pkg::COUNT_W-1:0]   used_next;
    logic [bba_pkg::INDEX_W-1:0]   result_next;

    // Words in use are ceil(limit/64), capped at the bitmap size.
    always_comb
    begin
        words_sum = {1'b0, limit_reg} + 12'd63;
        words_raw = words_sum[bba_pkg::COUNT_W:6];
        if (32'(words_raw) > bba_pkg::BITMAP_WORDS)
            words = bba_pkg::WCNT_W'(bba_pkg::BITMAP_WORDS);
        else
            words = bba_pkg::WCNT_W'(words_raw);
        cap = {words, 6'b0};
    end

    // Starting word of an allocate scan: the cursor's word, or word 0 when
    // the cursor lies beyond the words in use.
    always_comb
    begin
        if (32'(cursor_reg[9:6]) >= 32'(words))
            start_word = '0;
        else
            start_word = bba_pkg::WORD_W'(cursor_reg[9:6]);
        case (mode)
            bba_pkg::MODE_ALLOC: load_ptr = start_word;
            bba_pkg::MODE_NEXT:  load_ptr = bba_pkg::WORD_W'(block_index[9:6]);
            default:             load_ptr = '0;
        endcase
    end

    // Lowest set bit of the selected scan vector.
    always_comb
    begin
        cur_word   = bitmap_reg[ptr_reg];
        from_val   = (mode_reg == bba_pkg::MODE_FIRST) ? '0 : bidx_reg;
        first_mask = first_reg ? ~((64'd1 << from_val[5:0]) - 64'd1) : '1;
        if (mode_reg == bba_pkg::MODE_ALLOC)
            scan_vec = ~cur_word;
        else
            scan_vec = cur_word & first_mask;
        hit     = |scan_vec;
        hit_bit = '0;
        for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (scan_vec[b])
                hit_bit = 6'(b);
        end
        blk    = {ptr_reg, hit_bit};
        blk_p1 = {1'b0, blk} + 1'b1;
        if (32'(blk_p1) >= 32'(cap))
            cursor_next = '0;
        else
            cursor_next = bba_pkg::INDEX_W'(blk_p1);
    end

    // Word pointer advance, wrapping over the words in use.
    always_comb
    begin
        if (32'(ptr_reg) + 1 >= 32'(words))
            ptr_inc = '0;
        else
            ptr_inc = ptr_reg + 1'b1;
    end

    // Bit addressed by a free request.
    always_comb
    begin
        free_word = bba_pkg::WORD_W'(bidx_reg[9:6]);
        free_set  = bitmap_reg[free_word][bidx_reg[5:0]];
    end

    // Status for the controller.
    always_comb
    begin
        stat.mode       = mode_reg;
        stat.alloc_full = (used_reg >= limit_reg) || (words == '0);
        stat.pool_empty = (used_reg == '0);
        stat.range_err  = (32'(from_val) >= 32'(cap));
        stat.bit_clear  = !free_set;
        stat.hit        = hit;
        if (mode_reg == bba_pkg::MODE_ALLOC)
            stat.last = (32'(step_reg) + 1 >= 32'(words));
        else
            stat.last = (32'(ptr_reg) + 1 >= 32'(words));
    end

    // Used count after this request, and the index reported with it.
    always_comb
    begin
        used_next = used_reg;
        if (cmd.commit_alloc)
            used_next = used_reg + 1'b1;
        else if (cmd.commit_free)
            used_next = used_reg - 1'b1;
        if (cmd.code != bba_pkg::ST_OK)
            result_next = '0;
        else if (mode_reg == bba_pkg::MODE_FREE)
            result_next = bidx_reg;
        else
            result_next = bba_pkg::INDEX_W'(blk);
    end

    // Bitmap, counters, cursor and limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bba_pkg::BITMAP_WORDS; i++)
                bitmap_reg[i] <= '0;
            used_reg   <= '0;
            cursor_reg <= '0;
            limit_reg  <= bba_pkg::LIMIT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (cmd.commit_alloc)
            begin
                bitmap_reg[ptr_reg][hit_bit] <= 1'b1;
                cursor_reg <= cursor_next;
            end
            if (cmd.commit_free)
                bitmap_reg[free_word][bidx_reg[5:0]] <= 1'b0;
            used_reg <= used_next;
        end
    end

    // Request capture and scan position.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            bidx_reg  <= block_index;
            ptr_reg   <= load_ptr;
            step_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.scan_next)
        begin
            ptr_reg   <= ptr_inc;
            step_reg  <= step_reg + 1'b1;
            first_reg <= 1'b0;
        end
    end

    // Result strobe, shown for one cycle, and its payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg   <= cmd.code;
            result_reg   <= result_next;
            used_out_reg <= used_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_index = result_reg;
    assign used_count   = used_out_reg;

endmodule

@@ design/bba_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences each request: capture, checks, word-by-word scan and the single
// result transfer.
// ----------------------------------------------------------------------------
module bba_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bba_pkg::dp_status_t stat,
    output bba_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next       = state_reg;
        cmd.load         = 1'b0;
        cmd.scan_next    = 1'b0;
        cmd.commit_alloc = 1'b0;
        cmd.commit_free  = 1'b0;
        cmd.emit         = 1'b0;
        cmd.code         = bba_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (stat.mode == bba_pkg::MODE_ALLOC)
                begin
                    if (stat.alloc_full)
                    begin
                        cmd.emit = 1'b1;
                        cmd.code = bba_pkg::ST_FULL;
                    end
                    else
                        state_next = S_SCAN;
                end
                else if (stat.pool_empty)
                begin
                    cmd.emit = 1'b1;
                    cmd.code = bba_pkg::ST_EMPTY;
                end
                else if (stat.range_err)
                begin
                    cmd.emit = 1'b1;
                    cmd.code = bba_pkg::ST_RANGE;
                end
                else if (stat.mode == bba_pkg::MODE_FREE)
                begin
                    cmd.emit = 1'b1;
                    if (stat.bit_clear)
                        cmd.code = bba_pkg::ST_NOT_ALLOC;
                    else
                    begin
                        cmd.commit_free = 1'b1;
                        cmd.code        = bba_pkg::ST_OK;
                    end
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // One bitmap word is examined per cycle.
                if (stat.hit)
                begin
                    cmd.emit         = 1'b1;
                    cmd.code         = bba_pkg::ST_OK;
                    cmd.commit_alloc = (stat.mode == bba_pkg::MODE_ALLOC);
                    state_next       = S_IDLE;
                end
                else if (stat.last)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = (stat.mode == bba_pkg::MODE_ALLOC) ?
                                 bba_pkg::ST_FULL : bba_pkg::ST_NONE;
                    state_next = S_IDLE;
                end
                else
                    cmd.scan_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ design/bitmap_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Next-fit block allocator over a 64-bit-word busy bitmap, with free and
// busy-block search requests.
//
//   Channel   Signals                                Transfer
//   request   start, busy, mode, block_index         start high, busy low
//   result    done, status, result_index, used_count done high, one cycle
//   config    cfg_wr_en, cfg_wr_data (block_limit)   cfg_wr_en high
//
// An immediate answer is given from the check state; a scan visits n (1 to
// BITMAP_WORDS, 16) bitmap words, one per cycle. The result strobe rises in
// the same cycle as busy drops, and a new request may be taken in that cycle.
// Reset clears the bitmap, counters and cursor at once. The receiver cannot
// stall results.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bba_pkg::MODE_W-1:0]    mode,
    input  logic [bba_pkg::INDEX_W-1:0]   block_index,
    input  logic                          cfg_wr_en,
    input  logic [bba_pkg::COUNT_W-1:0]   cfg_wr_data,
    output logic                          done,
    output logic [bba_pkg::STAT_W-1:0]    status,
    output logic [bba_pkg::INDEX_W-1:0]   result_index,
    output logic [bba_pkg::COUNT_W-1:0]   used_count
);

    bba_pkg::dp_cmd_t    cmd;
    bba_pkg::dp_status_t stat;

    // Request sequencer.
    bba_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Bitmap storage and scan datapath.
    bba_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .block_index  (block_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .status       (status),
        .result_index (result_index),
        .used_count   (used_count)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate, free, first-busy and next-busy requests into the allocator
// and checks each result against a cycle-free model of the busy bitmap, the
// used count and the next-fit cursor. Phases switch the block limit while the
// unit is idle, from zero up to beyond the bitmap capacity, so that refusals,
// range errors, wrapped searches and a completely full bitmap are all reached.
// ----------------------------------------------------------------------------
module tb_top;

    import bba_pkg::*;

    // One request as it waits in the driver queue.
    typedef struct {
        logic [MODE_W-1:0]  op;
        logic [INDEX_W-1:0] idx;
    } alloc_req_t;

    // One predicted result.
    typedef struct {
        status_code_t       st;
        logic [INDEX_W-1:0] idx;
        logic [COUNT_W-1:0] cnt;
    } alloc_answer_t;

    localparam int SETTLE_CYCLES = 24;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [MODE_W-1:0]   mode = MODE_ALLOC;
    logic [INDEX_W-1:0]  block_index = '0;
    logic                cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                busy;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [INDEX_W-1:0]  result_index;
    logic [COUNT_W-1:0]  used_count;

    // Model of the allocator state.
    logic [WORD_BITS-1:0] busy_map [BITMAP_WORDS] = '{default: '0};
    logic [COUNT_W-1:0]   blocks_used = '0;
    logic [INDEX_W-1:0]   fit_cursor = '0;
    logic [COUNT_W-1:0]   blk_limit = LIMIT_RESET;

    alloc_req_t    pending_reqs [$];
    alloc_answer_t expected_answers [$];
    int            in_flight = 0;
    int            err_count = 0;
    int            gap_left = 0;
    bit            steady = 1'b0;
    bit            req_taken = 1'b0;

    bitmap_block_allocator_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .block_index  (block_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .status       (status),
        .result_index (result_index),
        .used_count   (used_count)
    );

    always #4 clk = ~clk;

    // Lowest set bit of a word at or above a start bit, 64 when none.
    function automatic int lowest_from(input logic [WORD_BITS-1:0] word, input int from);
        int b;
        for (b = from; b < WORD_BITS; b++)
        begin
            if (word[b])
                return b;
        end
        return WORD_BITS;
    endfunction

    // Applies one request to the model state and returns its answer.
    function automatic alloc_answer_t allocator_step(input logic [MODE_W-1:0] op,
                                                     input logic [INDEX_W-1:0] idx);
        alloc_answer_t ans;
        int words;
        int cap;
        int first_w;
        int w;
        int b;
        int i;
        int from;
        int nxt;
        words = (int'(blk_limit) + 63) / 64;
        if (words > BITMAP_WORDS)
            words = BITMAP_WORDS;
        cap = words * WORD_BITS;
        ans.st = ST_OK;
        ans.idx = '0;
        if (op == MODE_ALLOC)
        begin
            // Next-fit scan from the cursor's word, wrapping over the words in use.
            ans.st = ST_FULL;
            if (blocks_used < blk_limit && words != 0)
            begin
                first_w = int'(fit_cursor) >> 6;
                if (first_w >= words)
                    first_w = 0;
                for (i = 0; i < words && ans.st != ST_OK; i++)
                begin
                    w = (first_w + i) % words;
                    b = lowest_from(~busy_map[w], 0);
                    if (b < WORD_BITS)
                    begin
                        busy_map[w][b] = 1'b1;
                        blocks_used = blocks_used + 1'b1;
                        ans.st = ST_OK;
                        ans.idx = INDEX_W'(w * WORD_BITS + b);
                        nxt = w * WORD_BITS + b + 1;
                        if (nxt >= cap)
                            nxt = 0;
                        fit_cursor = INDEX_W'(nxt);
                    end
                end
            end
        end
        else if (blocks_used == 0)
        begin
            ans.st = ST_EMPTY;
        end
        else if (op == MODE_FREE)
        begin
            if (int'(idx) >= cap)
                ans.st = ST_RANGE;
            else if (!busy_map[idx[9:6]][idx[5:0]])
                ans.st = ST_NOT_ALLOC;
            else
            begin
                busy_map[idx[9:6]][idx[5:0]] = 1'b0;
                blocks_used = blocks_used - 1'b1;
                ans.idx = idx;
            end
        end
        else
        begin
            // Busy-block search from word zero or from the given index.
            from = (op == MODE_FIRST) ? 0 : int'(idx);
            if (from >= cap)
                ans.st = ST_RANGE;
            else
            begin
                ans.st = ST_NONE;
                b = from % WORD_BITS;
                for (w = from / WORD_BITS; w < words && ans.st != ST_OK; w++)
                begin
                    i = lowest_from(busy_map[w], b);
                    if (i < WORD_BITS)
                    begin
                        ans.st = ST_OK;
                        ans.idx = INDEX_W'(w * WORD_BITS + i);
                    end
                    b = 0;
                end
            end
        end
        ans.cnt = blocks_used;
        return ans;
    endfunction

    // Driver: presents queued requests and holds each until its transfer.
    always @(negedge clk)
    begin
        alloc_req_t item;
        if (!start || req_taken)
        begin
            req_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 9) == 0)
            begin
                gap_left = $urandom_range(1, 15) - 1;
                start <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                item = pending_reqs.pop_front();
                start <= 1'b1;
                mode <= item.op;
                block_index <= item.idx;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results against the oldest prediction, then predicts
    // the request transferred at this edge.
    always @(posedge clk)
    begin
        alloc_answer_t exp_ans;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d index %0d",
                           status, result_index);
                    err_count++;
                end
                else
                begin
                    exp_ans = expected_answers.pop_front();
                    in_flight--;
                    if (status !== exp_ans.st)
                    begin
                        $error("status: expected %0d, actual %0d", exp_ans.st, status);
                        err_count++;
                    end
                    if (result_index !== exp_ans.idx)
                    begin
                        $error("result_index: expected %0d, actual %0d",
                               exp_ans.idx, result_index);
                        err_count++;
                    end
                    if (used_count !== exp_ans.cnt)
                    begin
                        $error("used_count: expected %0d, actual %0d",
                               exp_ans.cnt, used_count);
                        err_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_answers.push_back(allocator_step(mode, block_index));
                req_taken = 1'b1;
            end
        end
    end

    task automatic push_request(input logic [MODE_W-1:0] op, input logic [INDEX_W-1:0] idx);
        alloc_req_t item;
        item.op = op;
        item.idx = idx;
        pending_reqs.push_back(item);
        in_flight++;
    endtask

    // Waits until every request has been answered and the unit is quiet.
    task automatic settle();
        while (in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        blk_limit = value;
    endtask

    // Random index: half over the whole range, half over the low blocks.
    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 1) == 0)
            return INDEX_W'($urandom_range(0, 1023));
        return INDEX_W'($urandom_range(0, 127));
    endfunction

    // Random mix of requests; weights are percentages for allocate and free.
    task automatic random_phase(input int count, input int pct_alloc, input int pct_free);
        int n;
        int roll;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < pct_alloc)
                push_request(MODE_ALLOC, pick_index());
            else if (roll < pct_alloc + pct_free)
                push_request(MODE_FREE, pick_index());
            else if (roll[0])
                push_request(MODE_FIRST, pick_index());
            else
                push_request(MODE_NEXT, pick_index());
        end
    endtask

    // Allocates until the whole bitmap is busy and a few more, with searches mixed in.
    task automatic fill_pool();
        int allocs;
        int need;
        need = 1024 - int'(blocks_used) + 4;
        allocs = 0;
        while (allocs < need)
        begin
            if ($urandom_range(0, 31) == 0)
                push_request(MODE_NEXT, pick_index());
            else
            begin
                push_request(MODE_ALLOC, pick_index());
                allocs++;
            end
        end
    endtask

    // Stall limit.
    initial
    begin
        #5_000_000;
        $display("bitmap_block_allocator_unit verification failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty pool answers, first allocations, free and search basics.
        write_limit(LIMIT_RESET);
        push_request(MODE_FREE, 10'd0);
        push_request(MODE_FIRST, 10'd0);
        push_request(MODE_NEXT, 10'd1023);
        push_request(MODE_ALLOC, 10'd1023);
        push_request(MODE_ALLOC, 10'd0);
        push_request(MODE_ALLOC, 10'd512);
        push_request(MODE_FREE, 10'd1);
        push_request(MODE_FREE, 10'd1);
        push_request(MODE_FIRST, 10'd1023);
        push_request(MODE_NEXT, 10'd1);
        push_request(MODE_NEXT, 10'd3);
        push_request(MODE_NEXT, 10'd1023);
        push_request(MODE_FREE, 10'd1023);
        push_request(MODE_ALLOC, 10'd0);

        // Two words in use: indexes past the capacity are out of range.
        write_limit(11'd70);
        push_request(MODE_FREE, 10'd1000);
        push_request(MODE_NEXT, 10'd128);
        push_request(MODE_NEXT, 10'd127);

        // A zero limit leaves no words in use at all.
        write_limit(11'd0);
        push_request(MODE_ALLOC, 10'd0);
        push_request(MODE_NEXT, 10'd0);
        push_request(MODE_FREE, 10'd0);
        push_request(MODE_FIRST, 10'd0);

        // Limit below the used count refuses allocation.
        write_limit(11'd2);
        push_request(MODE_ALLOC, 10'd0);

        // Random phases over several limits.
        write_limit(LIMIT_RESET);
        random_phase(80, 60, 20);
        write_limit(11'd1);
        random_phase(24, 40, 40);
        write_limit(11'd300);
        random_phase(50, 55, 25);

        // Limit above the capacity: the bitmap fills before the count limit.
        write_limit(11'd2047);
        fill_pool();
        write_limit(LIMIT_RESET);
        random_phase(16, 50, 20);

        // Small limit after a full bitmap: cursor outside, busy bits above limit.
        write_limit(11'd100);
        random_phase(50, 30, 40);

        // Last part without idle cycles, draining the pool.
        write_limit(LIMIT_RESET);
        steady = 1'b1;
        random_phase(70, 20, 60);

        settle();
        if (err_count == 0 && expected_answers.size() == 0)
            $display("bitmap_block_allocator_unit verification clean");
        else
            $display("bitmap_block_allocator_unit verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/bba_pkg.sv
design/bba_dp.sv
design/bba_ctrl.sv
design/bitmap_block_allocator_unit.sv
sim/tb_top.sv
